// ===== rtl/first_fit_region_allocator_top_macros.svh =====
// Assertion macros for the first-fit region allocator.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffra_pkg.sv =====
// Shared types and constants for the first-fit region allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

    localparam int NODE_COUNT = 64;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int LINK_W     = $clog2(NODE_COUNT + 1);
    localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(NODE_COUNT);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(NODE_COUNT - 1);

    localparam int IN_W     = 72;
    localparam int OUT_W    = 72;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEM    = 2'd1;
    localparam logic [1:0] ST_NO_NODES  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'b1;

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef struct packed {
        logic        free;
        logic [31:0] start;
        logic [31:0] length;
        link_t       prev;
        link_t       next;
    } node_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_WALK_START,
        OP_WALK,
        OP_EXACT,
        OP_SCAN_START,
        OP_SCAN,
        OP_SPLIT,
        OP_WRITE_H_USED,
        OP_RD_NEXT,
        OP_MERGE_NEXT,
        OP_RD_PREV,
        OP_MERGE_PREV,
        OP_WRITE_H,
        OP_RD_LINK,
        OP_FIX_LINK,
        OP_FAIL,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] err;
    } ctrl_t;

    typedef struct packed {
        logic head_avail;
        logic hit;
        logic walk_end;
        logic exact;
        logic spare_hit;
        logic scan_end;
        logic next_nil;
        logic prev_nil;
        logic link_nil;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ffra_ctrl.sv =====
// Command sequencer of the first-fit region allocator.
// Depends on ffra_pkg; drives the datapath through ctrl_t and reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module ffra_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_command,
    output logic                   in_ready,
    input  ffra_pkg::dp_stat_t     stat,
    output ffra_pkg::ctrl_t        ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_START,
        S_WALK,
        S_FIT,
        S_SCAN,
        S_SPLIT,
        S_WH,
        S_RNEXT,
        S_RNCHK,
        S_RPREV,
        S_RPCHK,
        S_LINK,
        S_FIX,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   alloc_reg, alloc_next;
    logic [1:0] miss_code;

    assign in_ready  = (state_reg == S_IDLE);
    assign miss_code = alloc_reg ? ffra_pkg::ST_NO_MEM : ffra_pkg::ST_NOT_FOUND;

    always_comb
    begin
        state_next = state_reg;
        alloc_next = alloc_reg;
        ctrl.op    = ffra_pkg::OP_NONE;
        ctrl.err   = ffra_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.op = ffra_pkg::OP_LOAD;
                    case (in_command)
                        ffra_pkg::CMD_INIT:
                            state_next = S_INIT;
                        ffra_pkg::CMD_ALLOC:
                        begin
                            alloc_next = 1'b1;
                            state_next = S_START;
                        end
                        ffra_pkg::CMD_RELEASE:
                        begin
                            alloc_next = 1'b0;
                            state_next = S_START;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_INIT:
            begin
                ctrl.op    = ffra_pkg::OP_INIT;
                state_next = S_DONE;
            end
            S_START:
            begin
                if (stat.head_avail)
                begin
                    ctrl.op    = ffra_pkg::OP_FAIL;
                    ctrl.err   = miss_code;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.op    = ffra_pkg::OP_WALK_START;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.hit)
                begin
                    ctrl.op    = ffra_pkg::OP_WALK;
                    state_next = alloc_reg ? S_FIT : S_RNEXT;
                end
                else if (stat.walk_end)
                begin
                    ctrl.op    = ffra_pkg::OP_FAIL;
                    ctrl.err   = miss_code;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.op = ffra_pkg::OP_WALK;
                end
            end
            S_FIT:
            begin
                if (stat.exact)
                begin
                    ctrl.op    = ffra_pkg::OP_EXACT;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.op    = ffra_pkg::OP_SCAN_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.spare_hit)
                begin
                    ctrl.op    = ffra_pkg::OP_SCAN;
                    state_next = S_SPLIT;
                end
                else if (stat.scan_end)
                begin
                    ctrl.op    = ffra_pkg::OP_FAIL;
                    ctrl.err   = ffra_pkg::ST_NO_NODES;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.op = ffra_pkg::OP_SCAN;
                end
            end
            S_SPLIT:
            begin
                ctrl.op    = ffra_pkg::OP_SPLIT;
                state_next = S_WH;
            end
            S_WH:
            begin
                ctrl.op    = ffra_pkg::OP_WRITE_H_USED;
                state_next = S_LINK;
            end
            S_RNEXT:
            begin
                if (stat.next_nil)
                begin
                    state_next = S_RPREV;
                end
                else
                begin
                    ctrl.op    = ffra_pkg::OP_RD_NEXT;
                    state_next = S_RNCHK;
                end
            end
            S_RNCHK:
            begin
                ctrl.op    = ffra_pkg::OP_MERGE_NEXT;
                state_next = S_RPREV;
            end
            S_RPREV:
            begin
                if (stat.prev_nil)
                begin
                    ctrl.op    = ffra_pkg::OP_WRITE_H;
                    state_next = S_LINK;
                end
                else
                begin
                    ctrl.op    = ffra_pkg::OP_RD_PREV;
                    state_next = S_RPCHK;
                end
            end
            S_RPCHK:
            begin
                ctrl.op    = ffra_pkg::OP_MERGE_PREV;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                if (stat.link_nil)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.op    = ffra_pkg::OP_RD_LINK;
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                ctrl.op    = ffra_pkg::OP_FIX_LINK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.op    = ffra_pkg::OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alloc_reg <= alloc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffra_dp.sv =====
// Datapath of the first-fit region allocator: descriptor memory, free map,
// walk and scan counters, free-byte count and result register. Depends on ffra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffra_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ffra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic [ffra_pkg::IN_W-1:0]         in_data,
    input  ffra_pkg::ctrl_t                        ctrl,
    output ffra_pkg::dp_stat_t                     stat,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [ffra_pkg::OUT_W-1:0]             out_data
);

    ffra_pkg::node_t mem [ffra_pkg::NODE_COUNT];
    ffra_pkg::node_t rdata_reg;

    logic [31:0] base_reg, size_cfg_reg;
    logic [31:0] fcount_reg, fcount_next;
    logic [ffra_pkg::NODE_COUNT-1:0] avail_reg, avail_next;
    logic        out_valid_reg;

    logic [31:0] req_size_reg, req_addr_reg;
    logic        is_alloc_reg;
    ffra_pkg::idx_t  cur_reg, cnt_reg, h_reg, spare_reg;
    ffra_pkg::node_t hw_reg;
    ffra_pkg::link_t owner_reg, link_reg;
    logic [1:0]  res_status_reg;
    logic [31:0] res_addr_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_addr_reg, out_free_reg;

    logic            rd_en, wr_en;
    ffra_pkg::idx_t  rd_addr, wr_addr;
    ffra_pkg::node_t wr_data, fix_word, hit_word, merge_word;
    logic            hit_alloc, hit_rel;

    assign hit_alloc = rdata_reg.free && (rdata_reg.length >= req_size_reg);
    assign hit_rel   = !rdata_reg.free && (rdata_reg.start == req_addr_reg);

    assign stat.head_avail = avail_reg[0];
    assign stat.hit        = is_alloc_reg ? hit_alloc : hit_rel;
    assign stat.walk_end   = (rdata_reg.next >= ffra_pkg::LINK_NIL)
                             || (cnt_reg == ffra_pkg::IDX_LAST);
    assign stat.exact      = (hw_reg.length == req_size_reg);
    assign stat.spare_hit  = avail_reg[cnt_reg];
    assign stat.scan_end   = (cnt_reg == ffra_pkg::IDX_LAST);
    assign stat.next_nil   = (hw_reg.next >= ffra_pkg::LINK_NIL);
    assign stat.prev_nil   = (hw_reg.prev >= ffra_pkg::LINK_NIL);
    assign stat.link_nil   = (link_reg >= ffra_pkg::LINK_NIL);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {6'd0, out_free_reg, out_addr_reg, out_status_reg};

    always_comb
    begin
        fix_word          = rdata_reg;
        fix_word.prev     = owner_reg;
        hit_word          = rdata_reg;
        hit_word.free     = rdata_reg.free || !is_alloc_reg;
        merge_word        = hw_reg;
        merge_word.length = hw_reg.length + rdata_reg.length;
        merge_word.next   = rdata_reg.next;
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = h_reg;
        wr_data = hw_reg;
        unique case (ctrl.op)
            ffra_pkg::OP_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{free: 1'b1, start: base_reg, length: size_cfg_reg,
                            prev: ffra_pkg::LINK_NIL, next: ffra_pkg::LINK_NIL};
            end
            ffra_pkg::OP_WALK_START:
            begin
                rd_en = 1'b1;
            end
            ffra_pkg::OP_WALK:
            begin
                rd_en   = !stat.hit;
                rd_addr = rdata_reg.next[ffra_pkg::IDX_W-1:0];
            end
            ffra_pkg::OP_EXACT:
            begin
                wr_en        = 1'b1;
                wr_data.free = 1'b0;
            end
            ffra_pkg::OP_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = spare_reg;
                wr_data = '{free: 1'b1, start: hw_reg.start + req_size_reg,
                            length: hw_reg.length - req_size_reg,
                            prev: ffra_pkg::link_t'(h_reg), next: hw_reg.next};
            end
            ffra_pkg::OP_WRITE_H_USED:
            begin
                wr_en          = 1'b1;
                wr_data.free   = 1'b0;
                wr_data.length = req_size_reg;
                wr_data.next   = ffra_pkg::link_t'(spare_reg);
            end
            ffra_pkg::OP_RD_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = hw_reg.next[ffra_pkg::IDX_W-1:0];
            end
            ffra_pkg::OP_RD_PREV:
            begin
                rd_en   = 1'b1;
                rd_addr = hw_reg.prev[ffra_pkg::IDX_W-1:0];
            end
            ffra_pkg::OP_MERGE_PREV:
            begin
                wr_en = 1'b1;
                if (rdata_reg.free)
                begin
                    wr_addr        = hw_reg.prev[ffra_pkg::IDX_W-1:0];
                    wr_data        = rdata_reg;
                    wr_data.length = rdata_reg.length + hw_reg.length;
                    wr_data.next   = hw_reg.next;
                end
            end
            ffra_pkg::OP_WRITE_H:
            begin
                wr_en = 1'b1;
            end
            ffra_pkg::OP_RD_LINK:
            begin
                rd_en   = 1'b1;
                rd_addr = link_reg[ffra_pkg::IDX_W-1:0];
            end
            ffra_pkg::OP_FIX_LINK:
            begin
                wr_en   = 1'b1;
                wr_addr = link_reg[ffra_pkg::IDX_W-1:0];
                wr_data = fix_word;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        fcount_next = fcount_reg;
        avail_next  = avail_reg;
        case (ctrl.op) inside
            ffra_pkg::OP_INIT:
            begin
                fcount_next   = size_cfg_reg;
                avail_next    = '1;
                avail_next[0] = 1'b0;
            end
            ffra_pkg::OP_WALK:
            begin
                if (stat.hit && !is_alloc_reg)
                begin
                    fcount_next = fcount_reg + rdata_reg.length;
                end
            end
            ffra_pkg::OP_EXACT, ffra_pkg::OP_SPLIT:
            begin
                fcount_next = fcount_reg - req_size_reg;
                if (ctrl.op == ffra_pkg::OP_SPLIT)
                begin
                    avail_next[spare_reg] = 1'b0;
                end
            end
            ffra_pkg::OP_MERGE_NEXT:
            begin
                if (rdata_reg.free)
                begin
                    avail_next[hw_reg.next[ffra_pkg::IDX_W-1:0]] = 1'b1;
                end
            end
            ffra_pkg::OP_MERGE_PREV:
            begin
                if (rdata_reg.free)
                begin
                    avail_next[h_reg] = 1'b1;
                end
            end
            default:
            begin
                fcount_next = fcount_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            size_cfg_reg  <= '0;
            fcount_reg    <= '0;
            avail_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ffra_pkg::REG_BASE)
                begin
                    base_reg <= cfg_data;
                end
                if (cfg_index == ffra_pkg::REG_SIZE)
                begin
                    size_cfg_reg <= cfg_data;
                end
            end
            fcount_reg <= fcount_next;
            avail_reg  <= avail_next;
            if (ctrl.op == ffra_pkg::OP_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            ffra_pkg::OP_LOAD:
            begin
                is_alloc_reg   <= (in_data[1:0] == ffra_pkg::CMD_ALLOC);
                req_size_reg   <= in_data[33:2];
                req_addr_reg   <= in_data[65:34];
                res_status_reg <= ffra_pkg::ST_OK;
                res_addr_reg   <= '0;
            end
            ffra_pkg::OP_WALK_START:
            begin
                cur_reg <= '0;
                cnt_reg <= '0;
            end
            ffra_pkg::OP_WALK:
            begin
                if (stat.hit)
                begin
                    h_reg  <= cur_reg;
                    hw_reg <= hit_word;
                end
                else
                begin
                    cur_reg <= rdata_reg.next[ffra_pkg::IDX_W-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ffra_pkg::OP_EXACT:
            begin
                res_addr_reg <= hw_reg.start;
            end
            ffra_pkg::OP_SCAN_START:
            begin
                cnt_reg <= '0;
            end
            ffra_pkg::OP_SCAN:
            begin
                if (stat.spare_hit)
                begin
                    spare_reg <= cnt_reg;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ffra_pkg::OP_SPLIT:
            begin
                res_addr_reg <= hw_reg.start;
                owner_reg    <= ffra_pkg::link_t'(spare_reg);
                link_reg     <= hw_reg.next;
            end
            ffra_pkg::OP_MERGE_NEXT:
            begin
                if (rdata_reg.free)
                begin
                    hw_reg <= merge_word;
                end
            end
            ffra_pkg::OP_MERGE_PREV:
            begin
                owner_reg <= rdata_reg.free ? hw_reg.prev : ffra_pkg::link_t'(h_reg);
                link_reg  <= hw_reg.next;
            end
            ffra_pkg::OP_WRITE_H:
            begin
                owner_reg <= ffra_pkg::link_t'(h_reg);
                link_reg  <= hw_reg.next;
            end
            ffra_pkg::OP_FAIL:
            begin
                res_status_reg <= ctrl.err;
                res_addr_reg   <= '0;
            end
            ffra_pkg::OP_DONE:
            begin
                out_status_reg <= res_status_reg;
                out_addr_reg   <= res_addr_reg;
                out_free_reg   <= fcount_reg;
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/first_fit_region_allocator_top.sv =====
// First-fit region allocator with coalescing: top level.
// Depends on ffra_pkg, ffra_ctrl, ffra_dp and the assertion macro header.
//
// Usage: configure region_base (index 0) and region_size (index 1) through
// cfg_we/cfg_index/cfg_data while idle, then send commands on the s_ channel.
// Each input item (init, allocate or release) gives exactly one result item
// on the m_ channel with status, block address and the free byte count.
// An init writes the first descriptor in S_INIT, then S_DONE registers the
// result. Allocate and release walk the descriptor list one node per cycle
// through the descriptor memory's single read port, an allocate that splits
// then searches the free map for a spare descriptor, and link fix-up follows.
// An unused command goes straight to S_DONE, and the most work is done by an
// allocate that walks the whole list and scans every free-map entry.
// A new item is taken only when the previous one has finished its work, but
// it may be taken while the previous result still waits in the output
// register. If the receiver stalls, the finished item waits until m_tready.
// Reset clears the configuration, the free count and marks every descriptor
// available; no clearing pass is needed, so items are accepted at once.
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_region_allocator_top_macros.svh"

module first_fit_region_allocator_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: command[2], request_size[32], release_address[32], zeros.
    input  wire logic [ffra_pkg::IN_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: status[2], block_address[32], free_bytes[32], zeros.
    output logic [ffra_pkg::OUT_W-1:0]           m_tdata
);

    ffra_pkg::ctrl_t    ctrl;
    ffra_pkg::dp_stat_t stat;

    ffra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tdata[1:0]),
        .in_ready   (s_tready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    ffra_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    `FFRA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `FFRA_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), $past(!s_tready), "result without work")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the first-fit region allocator top level.
// Needs ffra_pkg and first_fit_region_allocator_top; drives commands, predicts each result.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] NODE_USED  = 2'd0;
    localparam logic [1:0] NODE_FREE  = 2'd1;
    localparam logic [1:0] NODE_AVAIL = 2'd2;
    localparam int NIL = ffra_pkg::NODE_COUNT;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
        logic [31:0] free_bytes;
    } answer_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] size;
        logic [31:0] addr;
        bit          typed;
        answer_t     want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [ffra_pkg::IN_W-1:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [ffra_pkg::OUT_W-1:0] m_tdata;

    first_fit_region_allocator_top u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    logic [31:0] base_q, size_q, free_q;
    logic [1:0]  nst [ffra_pkg::NODE_COUNT];
    logic [31:0] nstart [ffra_pkg::NODE_COUNT];
    logic [31:0] nlen [ffra_pkg::NODE_COUNT];
    int          nprev [ffra_pkg::NODE_COUNT];
    int          nnext [ffra_pkg::NODE_COUNT];

    answer_t     pending_answers[$];
    logic [31:0] live_blocks[$];
    int          errors = 0;
    bit          long_hold = 0;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    function automatic void drop_node(int i);
        nst[i] = NODE_AVAIL;
        nprev[i] = NIL;
        nnext[i] = NIL;
    endfunction

    function automatic answer_t allocator_step(logic [1:0] cmd, logic [31:0] size,
                                               logic [31:0] addr);
        answer_t r;
        int h, cur, spare, n, p;
        r = '0;
        h = NIL;
        spare = NIL;
        if (cmd == ffra_pkg::CMD_INIT) begin
            for (int i = 0; i < ffra_pkg::NODE_COUNT; i++) drop_node(i);
            nst[0] = NODE_FREE;
            nstart[0] = base_q;
            nlen[0] = size_q;
            free_q = size_q;
        end else if (cmd == ffra_pkg::CMD_ALLOC) begin
            if (nst[0] != NODE_AVAIL) begin
                cur = 0;
                for (int s = 0; s < ffra_pkg::NODE_COUNT && cur < ffra_pkg::NODE_COUNT;
                     s++) begin
                    if (nst[cur] == NODE_FREE && nlen[cur] >= size) begin
                        h = cur;
                        break;
                    end
                    cur = nnext[cur];
                end
            end
            if (h == NIL) r.status = ffra_pkg::ST_NO_MEM;
            else if (nlen[h] == size) begin
                nst[h] = NODE_USED;
                free_q -= size;
                r.block_address = nstart[h];
            end else begin
                for (int i = 0; i < ffra_pkg::NODE_COUNT; i++)
                    if (nst[i] == NODE_AVAIL) begin
                        spare = i;
                        break;
                    end
                if (spare == NIL) r.status = ffra_pkg::ST_NO_NODES;
                else begin
                    free_q -= size;
                    nst[spare] = NODE_FREE;
                    nstart[spare] = nstart[h] + size;
                    nlen[spare] = nlen[h] - size;
                    nprev[spare] = h;
                    nnext[spare] = nnext[h];
                    if (nnext[spare] < ffra_pkg::NODE_COUNT) nprev[nnext[spare]] = spare;
                    nst[h] = NODE_USED;
                    nlen[h] = size;
                    nnext[h] = spare;
                    r.block_address = nstart[h];
                end
            end
            if (r.status == ffra_pkg::ST_OK) live_blocks.push_back(r.block_address);
        end else if (cmd == ffra_pkg::CMD_RELEASE) begin
            if (nst[0] != NODE_AVAIL) begin
                cur = 0;
                for (int s = 0; s < ffra_pkg::NODE_COUNT && cur < ffra_pkg::NODE_COUNT;
                     s++) begin
                    if (nst[cur] == NODE_USED && nstart[cur] == addr) begin
                        h = cur;
                        break;
                    end
                    cur = nnext[cur];
                end
            end
            if (h == NIL) r.status = ffra_pkg::ST_NOT_FOUND;
            else begin
                free_q += nlen[h];
                nst[h] = NODE_FREE;
                n = nnext[h];
                if (n < ffra_pkg::NODE_COUNT && nst[n] == NODE_FREE) begin
                    nlen[h] += nlen[n];
                    nnext[h] = nnext[n];
                    if (nnext[h] < ffra_pkg::NODE_COUNT) nprev[nnext[h]] = h;
                    drop_node(n);
                end
                p = nprev[h];
                if (p < ffra_pkg::NODE_COUNT && nst[p] == NODE_FREE) begin
                    nlen[p] += nlen[h];
                    nnext[p] = nnext[h];
                    if (nnext[h] < ffra_pkg::NODE_COUNT) nprev[nnext[h]] = p;
                    drop_node(h);
                end
            end
        end
        r.free_bytes = free_q;
        return r;
    endfunction

    task automatic write_reg(logic [ffra_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ffra_pkg::REG_BASE) base_q = val;
        else size_q = val;
        @(posedge clk);
    endtask

    task automatic send_command(logic [1:0] cmd, logic [31:0] size, logic [31:0] addr,
                                bit typed, answer_t want);
        answer_t got;
        int w;
        w = $urandom_range(0, 6);
        if (w != 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, addr, size, cmd};
        do @(posedge clk); while (!s_tready);
        got = allocator_step(cmd, size, addr);
        if (typed && got != want) begin
            $error("typed row disagrees with prediction: %h vs %h", want, got);
            errors++;
        end
        pending_answers.push_back(typed ? want : got);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic run_phase(logic [31:0] base, logic [31:0] size, int count);
        logic [31:0] a;
        int pick;
        drain();
        write_reg(ffra_pkg::REG_BASE, base);
        write_reg(ffra_pkg::REG_SIZE, size);
        live_blocks.delete();
        send_command(ffra_pkg::CMD_INIT, 0, 0, 0, '0);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 9) == 0) a = $urandom();
                else a = $urandom_range(0, (size >> 4) + 3);
                send_command(ffra_pkg::CMD_ALLOC, a, $urandom(), 0, '0);
            end else if (pick < 92 && live_blocks.size() != 0) begin
                int j = $urandom_range(0, live_blocks.size() - 1);
                a = live_blocks[j];
                live_blocks.delete(j);
                send_command(ffra_pkg::CMD_RELEASE, $urandom(), a, 0, '0);
            end else if (pick < 97) begin
                send_command(ffra_pkg::CMD_RELEASE, $urandom(), $urandom(), 0, '0);
            end else begin
                send_command(pick[0] ? ffra_pkg::CMD_INIT : CMD_UNUSED, $urandom(),
                             $urandom(), 0, '0);
                live_blocks.delete();
            end
        end
    endtask

    initial begin
        row_t rows[$];
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        rst_n = 0;
        base_q = 0;
        size_q = 0;
        free_q = 0;
        for (int i = 0; i < ffra_pkg::NODE_COUNT; i++) drop_node(i);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{ffra_pkg::CMD_ALLOC, 32'd16, 32'd0, 1, '{ffra_pkg::ST_NO_MEM, 32'd0, 32'd0}},
            '{ffra_pkg::CMD_RELEASE, 32'd0, 32'd0, 1,
              '{ffra_pkg::ST_NOT_FOUND, 32'd0, 32'd0}},
            '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{ffra_pkg::ST_OK, 32'd0, 32'd0}},
            '{ffra_pkg::CMD_INIT, 32'd0, 32'd0, 1, '{ffra_pkg::ST_OK, 32'd0, 32'd0}},
            '{ffra_pkg::CMD_ALLOC, 32'd0, 32'd0, 1, '{ffra_pkg::ST_OK, 32'd0, 32'd0}},
            '{ffra_pkg::CMD_RELEASE, 32'd0, 32'd0, 1, '{ffra_pkg::ST_OK, 32'd0, 32'd0}}
        };
        foreach (rows[i]) send_command(rows[i].cmd, rows[i].size, rows[i].addr,
                                       rows[i].typed, rows[i].want);
        drain();
        write_reg(ffra_pkg::REG_BASE, 32'hFFFF_FFF0);
        write_reg(ffra_pkg::REG_SIZE, 32'hFFFF_FFFF);
        rows = '{
            '{ffra_pkg::CMD_INIT, 32'd0, 32'd0, 1,
              '{ffra_pkg::ST_OK, 32'd0, 32'hFFFF_FFFF}},
            '{ffra_pkg::CMD_ALLOC, 32'd0, 32'd0, 1,
              '{ffra_pkg::ST_OK, 32'hFFFF_FFF0, 32'hFFFF_FFFF}},
            '{ffra_pkg::CMD_ALLOC, 32'h20, 32'd0, 1,
              '{ffra_pkg::ST_OK, 32'hFFFF_FFF0, 32'hFFFF_FFDF}},
            '{ffra_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 1,
              '{ffra_pkg::ST_NO_MEM, 32'd0, 32'hFFFF_FFDF}},
            '{ffra_pkg::CMD_ALLOC, 32'hFFFF_FFDF, 32'd0, 1,
              '{ffra_pkg::ST_OK, 32'h10, 32'd0}},
            '{ffra_pkg::CMD_RELEASE, 32'd0, 32'hFFFF_FFF0, 0, '0},
            '{ffra_pkg::CMD_RELEASE, 32'd0, 32'hFFFF_FFF0, 0, '0},
            '{ffra_pkg::CMD_RELEASE, 32'd0, 32'h10, 0, '0},
            '{ffra_pkg::CMD_RELEASE, 32'd0, 32'h10, 1,
              '{ffra_pkg::ST_NOT_FOUND, 32'd0, 32'hFFFF_FFFF}},
            '{ffra_pkg::CMD_INIT, 32'd0, 32'd0, 0, '0}
        };
        foreach (rows[i]) send_command(rows[i].cmd, rows[i].size, rows[i].addr,
                                       rows[i].typed, rows[i].want);
        // The receiver holds off while these allocates keep arriving.
        long_hold = 1;
        for (int i = 0; i < 66; i++) send_command(ffra_pkg::CMD_ALLOC, 32'd1, 32'd0, 0, '0);

        run_phase(32'h0000_1000, 32'd4096, 120);
        run_phase(32'd0, 32'd64, 80);
        run_phase(32'hFFFF_FF00, 32'd1024, 100);
        run_phase(32'h8000_0000, 32'hFFFF_FFFF, 60);
        drain();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold = 0;
            end
            w = $urandom_range(0, 6);
            if (w != 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk) begin
        answer_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.block_address = m_tdata[33:2];
            got.free_bytes = m_tdata[65:34];
            if (pending_answers.size() == 0) begin
                $error("result with no command outstanding: %h", got);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (got.status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.block_address != want.block_address) begin
                    $error("block_address: expected %h, got %h",
                           want.block_address, got.block_address);
                    errors++;
                end
                if (got.free_bytes != want.free_bytes) begin
                    $error("free_bytes: expected %h, got %h", want.free_bytes, got.free_bytes);
                    errors++;
                end
            end
        end
    end
endmodule
